### sv/multitap_keypad_text_entry_defines.svh
// ----------------------------------------------------------------------------
// multitap keypad text entry assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MKTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MKTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mkte_pkg.sv
// ----------------------------------------------------------------------------
// mkte_pkg
// shared types, constants and key character tables for the text entry block
// ----------------------------------------------------------------------------
`default_nettype none

package mkte_pkg;

    localparam int MAX_TEXT_DEF = 64;

    localparam int CNT_W   = 7;
    localparam int POS_W   = 6;
    localparam int TAP_W   = 6;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;
    localparam int KEY_W   = 4;
    localparam int OP_W    = 3;
    localparam int CHAR_W  = 8;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 16;

    localparam logic [CNT_W-1:0] MAX_LEN_RST = 7'd64;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;
    localparam logic [KEY_W-1:0] KEY_MAX     = 4'd9;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'h30;

    // opcodes
    localparam logic [OP_W-1:0] OP_TAP     = 3'd0;
    localparam logic [OP_W-1:0] OP_LONG    = 3'd1;
    localparam logic [OP_W-1:0] OP_BACK    = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd3;
    localparam logic [OP_W-1:0] OP_CONFIRM = 3'd4;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_MAX_LEN = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_TIMEOUT = 2'd1;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_step;
    } dp_cmd_t;

    typedef struct packed {
        logic readout;
        logic rd_last;
    } dp_sts_t;

    // character lists, cp437
    localparam logic [7:0] KEY0_ROM [2] = '{8'h20, 8'h30};
    localparam logic [7:0] KEY1_ROM [47] = '{
        8'h2E, 8'h40, 8'h3F, 8'h21, 8'h2C, 8'h3B, 8'h3A, 8'h27, 8'h22, 8'h28,
        8'h29, 8'h2D, 8'h5F, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h3D,
        8'h2F, 8'h5C, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h5E,
        8'h7E, 8'h60, 8'h31, 8'h9B, 8'h9C, 8'h9D, 8'hA8, 8'hAD, 8'hAE, 8'hAF,
        8'hAB, 8'hAC, 8'hF1, 8'hF8, 8'hFD, 8'hE6, 8'hF6};
    localparam logic [7:0] KEY2_ROM [18] = '{
        8'h61, 8'h62, 8'h63, 8'h41, 8'h42, 8'h43, 8'h32, 8'h84, 8'hA0, 8'h83,
        8'h85, 8'h86, 8'h91, 8'h8E, 8'h8F, 8'h92, 8'h87, 8'h80};
    localparam logic [7:0] KEY3_ROM [12] = '{
        8'h64, 8'h65, 8'h66, 8'h44, 8'h45, 8'h46, 8'h33, 8'h82, 8'h8A, 8'h88,
        8'h89, 8'h90};
    localparam logic [7:0] KEY4_ROM [11] = '{
        8'h67, 8'h68, 8'h69, 8'h47, 8'h48, 8'h49, 8'h34, 8'hA1, 8'h8D, 8'h8C,
        8'h8B};
    localparam logic [7:0] KEY5_ROM [7] = '{
        8'h6A, 8'h6B, 8'h6C, 8'h4A, 8'h4B, 8'h4C, 8'h35};
    localparam logic [7:0] KEY6_ROM [14] = '{
        8'h6D, 8'h6E, 8'h6F, 8'h4D, 8'h4E, 8'h4F, 8'h36, 8'hA2, 8'h95, 8'h93,
        8'h94, 8'h99, 8'hA4, 8'hA5};
    localparam logic [7:0] KEY7_ROM [10] = '{
        8'h70, 8'h71, 8'h72, 8'h73, 8'h50, 8'h51, 8'h52, 8'h53, 8'h37, 8'hE1};
    localparam logic [7:0] KEY8_ROM [12] = '{
        8'h74, 8'h75, 8'h76, 8'h54, 8'h55, 8'h56, 8'h38, 8'h81, 8'h9A, 8'hA3,
        8'h97, 8'h96};
    localparam logic [7:0] KEY9_ROM [10] = '{
        8'h77, 8'h78, 8'h79, 8'h7A, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h39, 8'h98};

    function automatic logic [TAP_W-1:0] key_len(input logic [KEY_W-1:0] key);
        logic [TAP_W-1:0] len;
        case (key)
            4'd0:    len = 6'd2;
            4'd1:    len = 6'd47;
            4'd2:    len = 6'd18;
            4'd3:    len = 6'd12;
            4'd4:    len = 6'd11;
            4'd5:    len = 6'd7;
            4'd6:    len = 6'd14;
            4'd7:    len = 6'd10;
            4'd8:    len = 6'd12;
            4'd9:    len = 6'd10;
            default: len = 6'd1;
        endcase
        return len;
    endfunction

    function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key,
                                                   input logic [TAP_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = 8'h00;
        if (idx < key_len(key))
        begin
            case (key)
                4'd0:    c = KEY0_ROM[idx[0]];
                4'd1:    c = KEY1_ROM[idx];
                4'd2:    c = KEY2_ROM[idx[4:0]];
                4'd3:    c = KEY3_ROM[idx[3:0]];
                4'd4:    c = KEY4_ROM[idx[3:0]];
                4'd5:    c = KEY5_ROM[idx[2:0]];
                4'd6:    c = KEY6_ROM[idx[3:0]];
                4'd7:    c = KEY7_ROM[idx[3:0]];
                4'd8:    c = KEY8_ROM[idx[3:0]];
                4'd9:    c = KEY9_ROM[idx[3:0]];
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/mkte_ctrl.sv
// ----------------------------------------------------------------------------
// mkte_ctrl
// sequencer: takes one item, runs the edit step, then streams any readout
// ----------------------------------------------------------------------------
`default_nettype none

module mkte_ctrl
    import mkte_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec = 1'b1;
                    if (sts.readout)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    cmd.rd_step    = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.rd_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/mkte_dp.sv
// ----------------------------------------------------------------------------
// mkte_dp
// edit state, text buffer, key tables and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module mkte_dp
    import mkte_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [CFG_D_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]    in_opcode,
    input  wire logic [KEY_W-1:0]   in_key,
    input  wire logic [TIME_W-1:0]  in_now,
    input  wire dp_cmd_t            cmd,
    output dp_sts_t                 sts,
    output logic                    res_kind,
    output logic [CHAR_W-1:0]       res_char,
    output logic [POS_W-1:0]        res_pos,
    output logic [CNT_W-1:0]        res_len,
    output logic                    res_cursor,
    output logic                    res_valid,
    output logic                    res_full,
    output logic                    res_last
);

    localparam int IDX_W = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT);

    // configuration
    logic [CNT_W-1:0]  max_len_reg;
    logic [TMO_W-1:0]  timeout_reg;

    // latched item
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;
    logic              timed_out_reg;

    // edit state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pend_reg, pend_next;
    logic [KEY_W-1:0]  digit_reg, digit_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic [TIME_W-1:0] press_reg, press_next;
    logic              cyc_reg, cyc_next;

    // readout walk
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CHAR_W-1:0] rd_data_reg;
    logic [CHAR_W-1:0] mem [MAX_TEXT];

    // step decode
    logic [CNT_W-1:0]  cap;
    logic              same;
    logic [TAP_W-1:0]  tap_inc;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_pos;
    logic [CHAR_W-1:0] wr_code;
    logic              st_full;
    logic [CHAR_W-1:0] digit_code;

    assign cap        = (max_len_reg > MAX_CNT) ? MAX_CNT : max_len_reg;
    assign same       = pend_reg && (digit_reg == key_reg);
    assign tap_inc    = tap_reg + 6'd1;
    assign digit_code = ASCII_ZERO + {4'b0000, key_reg};

    assign sts.readout = (op_reg == OP_CONFIRM) && (count_reg != '0);
    assign sts.rd_last = ((idx_reg + 7'd1) == count_reg);

    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg;
        digit_next = digit_reg;
        tap_next   = tap_reg;
        press_next = press_reg;
        cyc_next   = cyc_reg;
        wr_en      = 1'b0;
        wr_pos     = '0;
        wr_code    = '0;
        st_full    = 1'b0;
        case (op_reg)
            OP_TAP:
            begin
                if (key_reg <= KEY_MAX)
                begin
                    if (same && !timed_out_reg && (count_reg != '0))
                    begin
                        tap_next = (tap_inc >= key_len(key_reg)) ? '0 : tap_inc;
                        wr_en    = 1'b1;
                        wr_pos   = count_reg - 7'd1;
                        wr_code  = key_char(key_reg, tap_next);
                        cyc_next = 1'b1;
                    end
                    else if (count_reg < cap)
                    begin
                        wr_en      = 1'b1;
                        wr_pos     = count_reg;
                        wr_code    = key_char(key_reg, '0);
                        count_next = count_reg + 7'd1;
                        tap_next   = '0;
                        cyc_next   = 1'b1;
                    end
                    else
                    begin
                        st_full = 1'b1;
                    end
                    pend_next  = 1'b1;
                    digit_next = key_reg;
                    press_next = now_reg;
                end
            end
            OP_LONG:
            begin
                if (key_reg <= KEY_MAX)
                begin
                    // a long press always commits whatever was cycling
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        cyc_next  = 1'b0;
                    end
                    if (same && (count_reg != '0))
                    begin
                        wr_en   = 1'b1;
                        wr_pos  = count_reg - 7'd1;
                        wr_code = digit_code;
                    end
                    else if (count_reg < cap)
                    begin
                        wr_en      = 1'b1;
                        wr_pos     = count_reg;
                        wr_code    = digit_code;
                        count_next = count_reg + 7'd1;
                    end
                    else
                    begin
                        st_full = 1'b1;
                    end
                end
            end
            OP_BACK:
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - 7'd1;
                    pend_next  = 1'b0;
                    cyc_next   = 1'b0;
                end
            end
            OP_TICK:
            begin
                if (pend_reg && timed_out_reg)
                begin
                    pend_next = 1'b0;
                    cyc_next  = 1'b0;
                end
            end
            OP_CONFIRM:
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    cyc_next  = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.exec)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_step)
        begin
            idx_next = idx_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RST;
            timeout_reg <= TIMEOUT_RST;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            digit_reg   <= '0;
            tap_reg     <= '0;
            press_reg   <= '0;
            cyc_reg     <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MAX_LEN: max_len_reg <= cfg_data[CNT_W-1:0];
                    REG_TIMEOUT: timeout_reg <= cfg_data[TMO_W-1:0];
                    default:     max_len_reg <= max_len_reg;
                endcase
            end
            if (cmd.exec)
            begin
                count_reg <= count_next;
                pend_reg  <= pend_next;
                digit_reg <= digit_next;
                tap_reg   <= tap_next;
                press_reg <= press_next;
                cyc_reg   <= cyc_next;
            end
            idx_reg <= idx_next;
        end
    end

    // item latch; elapsed time is compared here so the step cycle stays short
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg        <= in_opcode;
            key_reg       <= in_key;
            now_reg       <= in_now;
            timed_out_reg <= (in_now - press_reg) > {16'h0000, timeout_reg};
        end
    end

    // text buffer, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_pos[IDX_W-1:0]] <= wr_code;
        end
        if (idx_next < MAX_CNT)
        begin
            rd_data_reg <= mem[idx_next[IDX_W-1:0]];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec && !sts.readout)
        begin
            res_kind   <= 1'b0;
            res_char   <= wr_en ? wr_code : '0;
            res_pos    <= wr_en ? wr_pos[POS_W-1:0] : '0;
            res_len    <= count_next;
            res_cursor <= cyc_next;
            res_valid  <= wr_en;
            res_full   <= st_full;
            res_last   <= 1'b1;
        end
        else if (cmd.rd_step)
        begin
            res_kind   <= 1'b1;
            res_char   <= rd_data_reg;
            res_pos    <= idx_reg[POS_W-1:0];
            res_len    <= count_reg;
            res_cursor <= cyc_reg;
            res_valid  <= 1'b1;
            res_full   <= 1'b0;
            res_last   <= sts.rd_last;
        end
    end

endmodule

`default_nettype wire

### sv/multitap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// multi-tap keypad text editor with confirm readout
//
// input stream: one key event per item (opcode in tuser, key and ms time
// in tdata). output stream: one status item per event, or for a confirm
// with text one item per stored character, tlast on the final one.
// config channel writes max_len (index 0) and the tap timeout in ms
// (index 1); write only while the block is idle.
// flow: a taken event is latched, then the edit step writes its status item
// to the result register once the output slot is free. a confirm readout
// follows the edit step and streams one character per cycle while the output
// takes them. the input takes the next event once the previous one has been
// fully handed to the output register, so it stays closed during a readout.
// reset: empty text, nothing pending, max_len 64, tap timeout 1000 ms; the
// buffer itself is not cleared.
// output stall: the result register holds until taken and the sequencer
// waits, so no item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multitap_keypad_text_entry_defines.svh"

module multitap_keypad_text_entry
    import mkte_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input events
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [39:0]        s_axis_tdata,  // key_digit[3:0], now_ms[35:4], zero pad
    input  wire logic [2:0]         s_axis_tuser,  // opcode[2:0]
    // results
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,  // char_code[7:0], position[13:8],
                                                   // text_length[20:14], cursor_on[21],
                                                   // char_valid[22], full_error[23]
    output logic                    m_axis_tuser,  // result_kind
    output logic                    m_axis_tlast,  // last
    // register writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_A_W-1:0] cfg_addr,
    input  wire logic [CFG_D_W-1:0] cfg_data
);

    dp_cmd_t           dp_cmd;
    dp_sts_t           dp_sts;
    logic [CHAR_W-1:0] res_char;
    logic [POS_W-1:0]  res_pos;
    logic [CNT_W-1:0]  res_len;
    logic              res_cursor;
    logic              res_valid;
    logic              res_full;

    // registers are always writable; the user keeps writes to idle time
    assign cfg_ready = 1'b1;

    mkte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    mkte_dp #(
        .MAX_TEXT (MAX_TEXT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_opcode  (s_axis_tuser),
        .in_key     (s_axis_tdata[3:0]),
        .in_now     (s_axis_tdata[35:4]),
        .cmd        (dp_cmd),
        .sts        (dp_sts),
        .res_kind   (m_axis_tuser),
        .res_char   (res_char),
        .res_pos    (res_pos),
        .res_len    (res_len),
        .res_cursor (res_cursor),
        .res_valid  (res_valid),
        .res_full   (res_full),
        .res_last   (m_axis_tlast)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {res_full, res_valid, res_cursor, res_len, res_pos, res_char};

    // the edit step and a readout step never fire together
    `MKTE_ASSERT_IMP(a_one_cmd, dp_cmd.exec, !dp_cmd.rd_step, "exec and readout step together")

    // one event at a time: after taking an event the input closes
    `MKTE_ASSERT_NXT(a_in_closes, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input still open after an event was taken")

    // the final readout character sits at the end of the text
    `MKTE_ASSERT_IMP(a_rd_tail, m_axis_tvalid && m_axis_tuser && m_axis_tlast,
        ({1'b0, res_pos} + 7'd1) == res_len, "readout ended away from the text end")

endmodule

`default_nettype wire

### dv/multitap_keypad_text_entry_tb.sv
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry_tb
// self-checking bench for the multi-tap text entry block
//
// key events go in from a queue through a clocked driver with random gaps.
// Results are taken by a monitor with random back-pressure. An in-bench
// model of the editor predicts each result, and the monitor compares every
// field in order. The run starts with a short directed sequence. Then come
// random phases, each under its own max_len / tap timeout setting: mostly
// well-formed tap words with random content, plus a fill-to-full run and
// some noise events.
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry_tb;

    import mkte_pkg::*;

    // result kinds as carried in m_axis_tuser
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CHAR   = 1'b1;

    // opcodes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_LO = OP_CONFIRM + 3'd1;
    localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

    // cycles allowed after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 8;
    // hard ceiling on the run, in time units
    localparam longint RUN_LIMIT = 64'd10_000_000;

    // character list of every key, first character in the top byte
    localparam logic [8*2-1:0]  GLYPH0 = " 0";
    localparam logic [8*47-1:0] GLYPH1 = {
        8'h2E, 8'h40, 8'h3F, 8'h21, 8'h2C, 8'h3B, 8'h3A, 8'h27, 8'h22, 8'h28,
        8'h29, 8'h2D, 8'h5F, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h3D,
        8'h2F, 8'h5C, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7C, 8'h5E,
        8'h7E, 8'h60, 8'h31, 8'h9B, 8'h9C, 8'h9D, 8'hA8, 8'hAD, 8'hAE, 8'hAF,
        8'hAB, 8'hAC, 8'hF1, 8'hF8, 8'hFD, 8'hE6, 8'hF6};
    localparam logic [8*18-1:0] GLYPH2 = {"abcABC2", 8'h84, 8'hA0, 8'h83, 8'h85,
        8'h86, 8'h91, 8'h8E, 8'h8F, 8'h92, 8'h87, 8'h80};
    localparam logic [8*12-1:0] GLYPH3 = {"defDEF3", 8'h82, 8'h8A, 8'h88, 8'h89, 8'h90};
    localparam logic [8*11-1:0] GLYPH4 = {"ghiGHI4", 8'hA1, 8'h8D, 8'h8C, 8'h8B};
    localparam logic [8*7-1:0]  GLYPH5 = "jklJKL5";
    localparam logic [8*14-1:0] GLYPH6 = {"mnoMNO6", 8'hA2, 8'h95, 8'h93, 8'h94,
        8'h99, 8'hA4, 8'hA5};
    localparam logic [8*10-1:0] GLYPH7 = {"pqrsPQRS7", 8'hE1};
    localparam logic [8*12-1:0] GLYPH8 = {"tuvTUV8", 8'h81, 8'h9A, 8'hA3, 8'h97, 8'h96};
    localparam logic [8*10-1:0] GLYPH9 = {"wxyzWXYZ9", 8'h98};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic              hold;   // sender waits for all results before this item
    } key_event_t;

    typedef struct packed {
        logic              result_kind;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  text_length;
        logic              cursor_on;
        logic              char_valid;
        logic              full_error;
        logic              last;
    } text_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata = '0;   // key_digit[3:0], now_ms[35:4], zero pad
    logic [2:0]         s_axis_tuser = '0;   // opcode[2:0]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;        // char_code, position, text_length,
                                             // cursor_on, char_valid, full_error
    logic               m_axis_tuser;        // result_kind
    logic               m_axis_tlast;        // last
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_D_W-1:0] cfg_data = '0;

    // stimulus and expectations
    key_event_t   key_events[$];
    text_result_t due_results[$];
    logic [TIME_W-1:0] ms_clock = '0;
    int mismatches = 0;

    // editor state as predicted by the bench
    logic [CHAR_W-1:0] entered_chars [64];
    logic [CNT_W-1:0]  text_len = '0;
    logic              key_open = 1'b0;
    logic [KEY_W-1:0]  open_key = '0;
    logic [TAP_W-1:0]  cycle_pos = '0;
    logic [TIME_W-1:0] press_ms = '0;
    logic              cursor_live = 1'b0;
    logic [CNT_W-1:0]  max_len_reg = MAX_LEN_RST;
    logic [TMO_W-1:0]  timeout_reg = TIMEOUT_RST;

    // handshakes seen at the last rising edge
    bit in_fire = 1'b0;
    bit out_fire = 1'b0;

    // driver / receiver pacing
    key_event_t next_ev;
    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;

    always #5 clk = ~clk;

    multitap_keypad_text_entry dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    function automatic int key_span(input logic [KEY_W-1:0] key);
        case (key)
            4'd0:    return 2;
            4'd1:    return 47;
            4'd2:    return 18;
            4'd3:    return 12;
            4'd4:    return 11;
            4'd5:    return 7;
            4'd6:    return 14;
            4'd7:    return 10;
            4'd8:    return 12;
            4'd9:    return 10;
            default: return 1;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] key_glyph(input logic [KEY_W-1:0] key,
                                                    input int idx);
        logic [8*47-1:0] row;
        case (key)
            4'd0:    row = GLYPH0;
            4'd1:    row = GLYPH1;
            4'd2:    row = GLYPH2;
            4'd3:    row = GLYPH3;
            4'd4:    row = GLYPH4;
            4'd5:    row = GLYPH5;
            4'd6:    row = GLYPH6;
            4'd7:    row = GLYPH7;
            4'd8:    row = GLYPH8;
            4'd9:    row = GLYPH9;
            default: row = '0;
        endcase
        return row[8*(key_span(key) - 1 - idx) +: 8];
    endfunction

    // a pending tapped character becomes final
    function automatic void commit_key();
        if (key_open)
        begin
            key_open = 1'b0;
            cursor_live = 1'b0;
        end
    endfunction

    // work out the results of one accepted key event and queue them
    task automatic predict_entry(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [TIME_W-1:0] now);
        text_result_t r;
        logic [TIME_W-1:0] elapsed;
        logic [CNT_W-1:0] cap;
        logic [CHAR_W-1:0] code;
        logic [POS_W-1:0] pos;
        logic valid, full, late, digit_ok, readout;
        int n, i;
        elapsed = now - press_ms;
        late = elapsed > TIME_W'(timeout_reg);
        cap = (max_len_reg > CNT_W'(MAX_TEXT_DEF)) ? CNT_W'(MAX_TEXT_DEF) : max_len_reg;
        digit_ok = key <= 4'd9;
        valid = 1'b0;
        full = 1'b0;
        readout = 1'b0;
        code = '0;
        pos = '0;
        if (op == OP_TAP && digit_ok)
        begin
            if (key_open && open_key == key && !late && text_len > 0)
            begin
                // same key in time: step through its list, overwrite last char
                cycle_pos = cycle_pos + 1'b1;
                if (cycle_pos >= key_span(key))
                    cycle_pos = '0;
                pos = POS_W'(text_len - 1'b1);
                code = key_glyph(key, cycle_pos);
                entered_chars[pos] = code;
                cursor_live = 1'b1;
                valid = 1'b1;
            end
            else if (text_len < cap)
            begin
                pos = POS_W'(text_len);
                code = key_glyph(key, 0);
                entered_chars[pos] = code;
                text_len = text_len + 1'b1;
                cycle_pos = '0;
                cursor_live = 1'b1;
                valid = 1'b1;
            end
            else
                full = 1'b1;
            // even a refused tap becomes the pending key
            key_open = 1'b1;
            open_key = key;
            press_ms = now;
        end
        else if (op == OP_LONG && digit_ok)
        begin
            code = ASCII_ZERO + CHAR_W'(key);
            if (key_open && open_key == key && text_len > 0)
            begin
                pos = POS_W'(text_len - 1'b1);
                entered_chars[pos] = code;
                commit_key();
                valid = 1'b1;
            end
            else
            begin
                commit_key();
                if (text_len < cap)
                begin
                    pos = POS_W'(text_len);
                    entered_chars[pos] = code;
                    text_len = text_len + 1'b1;
                    valid = 1'b1;
                end
                else
                    full = 1'b1;
            end
        end
        else if (op == OP_BACK)
        begin
            if (text_len > 0)
            begin
                text_len = text_len - 1'b1;
                key_open = 1'b0;
                cursor_live = 1'b0;
            end
        end
        else if (op == OP_TICK)
        begin
            if (key_open && late)
                commit_key();
        end
        else if (op == OP_CONFIRM)
        begin
            commit_key();
            if (text_len > 0)
            begin
                readout = 1'b1;
                n = text_len;
                for (i = 0; i < n; i++)
                begin
                    r.result_kind = KIND_CHAR;
                    r.char_code = entered_chars[i];
                    r.position = POS_W'(i);
                    r.text_length = text_len;
                    r.cursor_on = cursor_live;
                    r.char_valid = 1'b1;
                    r.full_error = 1'b0;
                    r.last = (i == n - 1);
                    due_results.push_back(r);
                end
            end
        end
        // anything else: out-of-range key or spare opcode, plain status only
        if (!readout)
        begin
            r.result_kind = KIND_STATUS;
            r.char_code = valid ? code : '0;
            r.position = valid ? pos : '0;
            r.text_length = text_len;
            r.cursor_on = cursor_live;
            r.char_valid = valid;
            r.full_error = full;
            r.last = 1'b1;
            due_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_event(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [TIME_W-1:0] now, input logic hold);
        key_event_t ev;
        ev.op = op;
        ev.key = key;
        ev.now = now;
        ev.hold = hold;
        key_events.push_back(ev);
    endtask

    // move the ms clock: within the timeout, or past it
    task automatic advance(input bit late);
        if (late)
            ms_clock += TIME_W'(timeout_reg) + 32'd1 + $urandom_range(0, 3000);
        else
            ms_clock += $urandom_range(0, timeout_reg);
    endtask

    // random typing: mostly tap words, with long presses, edits and some noise
    task automatic type_words(input int n);
        int target, pick, taps, follow, i;
        logic [KEY_W-1:0] key;
        target = key_events.size() + n;
        while (key_events.size() < target)
        begin
            pick = $urandom_range(0, 99);
            key = KEY_W'($urandom_range(0, 9));
            if (pick < 50)
            begin
                // one word; now and then run the whole list and wrap around
                taps = ($urandom_range(0, 5) == 0) ? key_span(key) + 1 : $urandom_range(1, 4);
                for (i = 0; i < taps && key_events.size() < target; i++)
                begin
                    advance(1'b0);
                    queue_event(OP_TAP, key, ms_clock, $urandom_range(0, 14) == 0);
                end
                follow = $urandom_range(0, 9);
                if (follow < 3)
                begin
                    advance(1'b0);
                    queue_event(OP_LONG, key, ms_clock, 1'b0);
                end
                else if (follow < 6)
                begin
                    advance(1'b1);
                    queue_event(OP_TICK, KEY_W'($urandom_range(0, 15)), ms_clock, 1'b0);
                end
            end
            else if (pick < 62)
            begin
                advance($urandom_range(0, 1));
                queue_event(OP_LONG, key, ms_clock, 1'b0);
            end
            else if (pick < 72)
            begin
                advance(1'b0);
                queue_event(OP_BACK, key, ms_clock, 1'b0);
            end
            else if (pick < 82)
            begin
                advance($urandom_range(0, 1));
                queue_event(OP_TICK, key, ms_clock, 1'b0);
            end
            else if (pick < 88)
            begin
                advance($urandom_range(0, 1));
                queue_event(OP_CONFIRM, key, ms_clock, $urandom_range(0, 3) == 0);
            end
            else
            begin
                // noise: any opcode, any key, a jump anywhere on the ms clock
                ms_clock = $urandom;
                queue_event(OP_W'($urandom_range(0, 7)), KEY_W'($urandom_range(0, 15)),
                            ms_clock, 1'b0);
            end
        end
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MAX_LEN)
            max_len_reg = val[CNT_W-1:0];
        else if (idx == REG_TIMEOUT)
            timeout_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every event is taken and every result has arrived
    task automatic settle();
        while (key_events.size() > 0 || s_axis_tvalid || due_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sample both handshakes, predict taken events, check delivered results
    always @(posedge clk)
    begin
        text_result_t want;
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (in_fire)
            predict_entry(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[35:4]);
        if (out_fire)
        begin
            if (due_results.size() == 0)
            begin
                $error("result item with none expected: kind %0d data %h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("result_kind", want.result_kind, m_axis_tuser);
                check_field("char_code", want.char_code, m_axis_tdata[7:0]);
                check_field("position", want.position, m_axis_tdata[13:8]);
                check_field("text_length", want.text_length, m_axis_tdata[20:14]);
                check_field("cursor_on", want.cursor_on, m_axis_tdata[21]);
                check_field("char_valid", want.char_valid, m_axis_tdata[22]);
                check_field("full_error", want.full_error, m_axis_tdata[23]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // event driver: random gap before each item, back-to-back stretches now and then
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_fire)
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (key_events.size() > 0 &&
                     !(key_events[0].hold && due_results.size() > 0))
            begin
                next_ev = key_events.pop_front();
                s_axis_tuser <= next_ev.op;
                s_axis_tdata <= {4'b0, next_ev.now, next_ev.key};
                s_axis_tvalid <= 1'b1;
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_wait = 0;
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    send_calm = $urandom_range(6, 20);
                    send_wait = 0;
                end
                else
                    send_wait = $urandom_range(0, 18);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver: random stall after each item taken
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (out_fire)
            begin
                if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_wait = 0;
                end
                else if ($urandom_range(0, 11) == 0)
                begin
                    recv_calm = $urandom_range(6, 20);
                    recv_wait = 0;
                end
                else
                    recv_wait = $urandom_range(0, 18);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("multitap_keypad_text_entry: mismatch");
        $finish;
    end

    initial
    begin
        int i;
        logic [KEY_W-1:0] key;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings written explicitly
        write_reg(REG_MAX_LEN, 16'd64);
        write_reg(REG_TIMEOUT, 16'd1000);
        queue_event(OP_BACK, 4'd0, 32'd0, 1'b0);           // backspace on empty text
        queue_event(OP_CONFIRM, 4'd0, 32'd0, 1'b0);        // confirm on empty text
        queue_event(OP_TICK, 4'd0, 32'd5, 1'b0);           // tick, nothing pending
        queue_event(OP_TAP, 4'd2, 32'd1000, 1'b0);         // append 'a'
        queue_event(OP_TAP, 4'd2, 32'd2000, 1'b0);         // exactly at timeout: still cycles
        queue_event(OP_TAP, 4'd2, 32'd2100, 1'b0);
        queue_event(OP_TICK, 4'd0, 32'd3100, 1'b0);        // elapsed == timeout, no commit
        queue_event(OP_TICK, 4'd0, 32'd3101, 1'b0);        // one past, commit
        queue_event(OP_TAP, 4'd2, 32'd3200, 1'b0);         // new char after commit
        queue_event(OP_LONG, 4'd2, 32'd3300, 1'b0);        // long press replaces pending char
        queue_event(OP_LONG, 4'd5, 32'd3400, 1'b0);        // long press appends digit
        queue_event(OP_TAP, 4'd9, 32'hFFFF_FFFF, 1'b0);
        queue_event(OP_TAP, 4'd9, 32'h0000_0000, 1'b0);    // ms clock wraps, still cycles
        queue_event(OP_TICK, 4'd0, 32'h0000_0300, 1'b0);
        queue_event(OP_TAP, 4'd0, 32'h0000_0400, 1'b0);
        queue_event(OP_TAP, 4'd0, 32'h0000_0401, 1'b0);
        queue_event(OP_TAP, 4'd0, 32'h0000_0402, 1'b0);    // tap list wraps to first char
        queue_event(OP_TAP, 4'd15, 32'h0000_0403, 1'b0);   // key out of range
        queue_event(OP_LONG, 4'd10, 32'h0000_0404, 1'b0);
        queue_event(OP_SPARE_LO, 4'd0, 32'hAAAA_5555, 1'b0);
        queue_event(OP_SPARE_HI, 4'd15, 32'h5555_AAAA, 1'b0);
        queue_event(OP_BACK, 4'd0, 32'h0000_0500, 1'b0);
        queue_event(OP_TAP, 4'd1, 32'h0000_0600, 1'b0);
        queue_event(OP_CONFIRM, 4'd0, 32'h0000_0700, 1'b1);
        ms_clock = 32'h0000_0700;
        settle();

        // tiny text and zero timeout: only same-ms taps cycle
        write_reg(REG_MAX_LEN, 16'd3);
        write_reg(REG_TIMEOUT, 16'd0);
        type_words(12);
        queue_event(OP_CONFIRM, 4'd0, ms_clock, 1'b1);
        settle();

        // no room at all, longest timeout
        write_reg(REG_MAX_LEN, 16'd0);
        write_reg(REG_TIMEOUT, 16'hFFFF);
        type_words(8);
        settle();

        // length setting above the buffer size acts as full size: fill it up
        write_reg(REG_MAX_LEN, 16'd127);
        key = 4'd0;
        for (i = 0; i < 68; i++)
        begin
            // a different key each time so every event appends until the text is full
            key = KEY_W'((key + $urandom_range(1, 9)) % 10);
            advance(1'b0);
            queue_event($urandom_range(0, 1) ? OP_TAP : OP_LONG, key, ms_clock,
                        $urandom_range(0, 19) == 0);
        end
        queue_event(OP_CONFIRM, 4'd0, ms_clock, 1'b0);
        settle();

        // mid-range settings
        write_reg(REG_MAX_LEN, 16'd8);
        write_reg(REG_TIMEOUT, 16'd500);
        type_words(16);
        queue_event(OP_CONFIRM, 4'd0, ms_clock, 1'b0);
        settle();

        if (mismatches == 0)
            $display("multitap_keypad_text_entry: match");
        else
            $display("multitap_keypad_text_entry: mismatch");
        $finish;
    end

endmodule
